// ----- src/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and the parse step function
// Beat types for both channels, parser state codes, action codes and the
// byte classifier that the escape sequence scanner applies to every byte.
// ----------------------------------------------------------------------------
package aes_pkg;

  // Capacity of the store for a partial sequence, in bytes.
  localparam int MAX_HELD   = 32;
  // Held count and ring pointers; the ring holds MAX_HELD plus the new byte.
  localparam int CNT_W      = $clog2(MAX_HELD + 1);
  localparam int PTR_W      = $clog2(MAX_HELD + 1);
  localparam int RING_DEPTH = 1 << PTR_W;

  // Byte codes.
  localparam logic [7:0] ESC_CODE  = 8'h1B;
  localparam logic [7:0] BEL_CODE  = 8'h07;
  localparam logic [7:0] CSI_CODE  = 8'h5B;  // '['
  localparam logic [7:0] OSC_CODE  = 8'h5D;  // ']'
  localparam logic [7:0] ST_CODE   = 8'h5C;  // '\'
  localparam logic [7:0] PAR_LO    = 8'h30;
  localparam logic [7:0] PAR_HI    = 8'h3F;
  localparam logic [7:0] INT_LO    = 8'h20;
  localparam logic [7:0] INT_HI    = 8'h2F;
  localparam logic [7:0] FIN_LO    = 8'h40;
  localparam logic [7:0] FIN_HI    = 8'h7E;
  localparam logic [7:0] ESC2_HI   = 8'h5F;

  // Request codes.
  localparam logic REQ_DATA    = 1'b0;
  localparam logic REQ_DISCARD = 1'b1;

  // Parser states for the held partial sequence.
  localparam int PST_W = 3;
  localparam logic [PST_W-1:0] PST_EMPTY   = 3'd0;
  localparam logic [PST_W-1:0] PST_ESC     = 3'd1;
  localparam logic [PST_W-1:0] PST_CSI_PAR = 3'd2;
  localparam logic [PST_W-1:0] PST_CSI_INT = 3'd3;
  localparam logic [PST_W-1:0] PST_OSC     = 3'd4;
  localparam logic [PST_W-1:0] PST_OSC_ESC = 3'd5;

  // What one byte does to the scan.
  localparam logic [1:0] ACT_LIT  = 2'd0;  // literal, pass it on
  localparam logic [1:0] ACT_HOLD = 2'd1;  // sequence goes on, hold the byte
  localparam logic [1:0] ACT_DONE = 2'd2;  // sequence complete, drop it
  localparam logic [1:0] ACT_BAD  = 2'd3;  // malformed or too long

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]       act;
    logic [PST_W-1:0] nst;
  } trans_t;

  // Load request from the scanner into the output register.
  typedef struct packed {
    logic      load;
    out_beat_t beat;
  } out_load_t;

  // One parse step: current state, held count and the next byte.
  function automatic trans_t aes_step(input logic [PST_W-1:0] pst,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic [7:0] b);
    trans_t t;
    t.act = ACT_BAD;
    t.nst = PST_EMPTY;
    case (pst)
      PST_EMPTY: begin
        if (b == ESC_CODE) begin
          t.act = ACT_HOLD;
          t.nst = PST_ESC;
        end else begin
          t.act = ACT_LIT;
        end
      end
      PST_ESC: begin
        if (b == CSI_CODE) begin
          t.act = ACT_HOLD;
          t.nst = PST_CSI_PAR;
        end else if (b == OSC_CODE) begin
          t.act = ACT_HOLD;
          t.nst = PST_OSC;
        end else if (b inside {[FIN_LO:ESC2_HI]}) begin
          t.act = ACT_DONE;
        end
      end
      PST_CSI_PAR: begin
        if (b inside {[PAR_LO:PAR_HI]}) begin
          t.act = ACT_HOLD;
          t.nst = PST_CSI_PAR;
        end else if (b inside {[INT_LO:INT_HI]}) begin
          t.act = ACT_HOLD;
          t.nst = PST_CSI_INT;
        end else if (b inside {[FIN_LO:FIN_HI]}) begin
          t.act = ACT_DONE;
        end
      end
      PST_CSI_INT: begin
        if (b inside {[INT_LO:INT_HI]}) begin
          t.act = ACT_HOLD;
          t.nst = PST_CSI_INT;
        end else if (b inside {[FIN_LO:FIN_HI]}) begin
          t.act = ACT_DONE;
        end
      end
      PST_OSC: begin
        if (b == BEL_CODE) begin
          t.act = ACT_DONE;
        end else if (b == ESC_CODE) begin
          t.act = ACT_HOLD;
          t.nst = PST_OSC_ESC;
        end else begin
          t.act = ACT_HOLD;
          t.nst = PST_OSC;
        end
      end
      PST_OSC_ESC: begin
        if (b == ST_CODE) begin
          t.act = ACT_DONE;
        end
      end
      default: begin
        t.act = ACT_BAD;
      end
    endcase
    // A sequence that would grow past the store is treated as malformed.
    if (t.act == ACT_HOLD && cnt == CNT_W'(MAX_HELD)) begin
      t.act = ACT_BAD;
      t.nst = PST_EMPTY;
    end
    return t;
  endfunction

endpackage

// ----- src/aes_ram.sv -----
// ----------------------------------------------------------------------------
// aes_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued. A read of the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/aes_outreg.sv -----
// ----------------------------------------------------------------------------
// aes_outreg: result channel output register
// Holds one result beat until the consumer takes it and tells the scanner
// whether a new beat can be loaded in this cycle.
// ----------------------------------------------------------------------------
module aes_outreg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aes_pkg::out_load_t   ld,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aes_pkg::out_beat_t   out_data
);
  import aes_pkg::*;

  logic      out_valid_r;
  out_beat_t out_data_r;

  // The slot is free when empty or when its beat leaves in this cycle.
  assign free      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (ld.load) begin
      out_data_r <= ld.beat;
    end
  end

endmodule

// ----- src/aes_scan.sv -----
// ----------------------------------------------------------------------------
// aes_scan: escape sequence scanner around the held byte ring
// Parses one byte per cycle while the output register is free, against the
// held partial sequence. Every data byte is written to a ring memory; a
// malformed or overlong sequence sends its leading ESC out and re-reads
// the bytes after it from the ring.
module aes_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aes_pkg::in_beat_t    in_data,
  input  logic                 free,
  output aes_pkg::out_load_t   ld
);
  import aes_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]       fsm_r, fsm_nxt;
  logic [PST_W-1:0] pst_r, pst_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] cur_r, cur_nxt;
  logic [PTR_W-1:0] end_r, end_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic             fwd_r, fwd_nxt;
  logic [7:0]       fwd_byte_r;

  logic             accept;
  logic             step_fire;
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] pos;
  logic             at_end;
  logic [7:0]       cur_byte;
  logic [7:0]       rd_data;
  trans_t           tr;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             consumed;
  logic             scan_end;
  logic             ram_we;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;

  assign in_ready = (fsm_r == S_IDLE) && free;
  assign accept   = in_valid && in_ready;
  assign wp       = head_r + PTR_W'(cnt_r);

  // Byte under the scanner: the new beat, or a byte re-read from the ring.
  assign cur_byte  = (fsm_r == S_EXEC) ? (fwd_r ? fwd_byte_r : rd_data) : in_data.in_byte;
  assign pos       = (fsm_r == S_EXEC) ? cur_r : wp;
  assign at_end    = (fsm_r == S_EXEC) ? (cur_r == end_r) : 1'b1;
  assign step_fire = (accept && in_data.req_type == REQ_DATA) ||
                     ((fsm_r == S_EXEC) && free);

  assign tr        = aes_step(pst_r, cnt_r, cur_byte);
  assign emit      = (tr.act == ACT_LIT) || (tr.act == ACT_BAD);
  assign emit_byte = (tr.act == ACT_BAD) ? ESC_CODE : cur_byte;
  assign consumed  = (tr.act != ACT_BAD);
  assign scan_end  = consumed && at_end;

  // Ring memory access: write the new byte, read ahead for the rescan.
  assign ram_we    = accept && (in_data.req_type == REQ_DATA);
  assign ram_re    = step_fire && !scan_end;
  assign ram_raddr = (tr.act == ACT_BAD) ? (head_r + PTR_W'(1)) : (pos + PTR_W'(1));

  aes_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (in_data.in_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Next state of the parser, the ring pointers and the pending result.
  always_comb begin
    fsm_nxt    = fsm_r;
    pst_nxt    = pst_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    fwd_nxt    = fwd_r;
    ld.load    = 1'b0;
    ld.beat    = '{out_byte: pend_r, last_byte: 1'b0};

    if (accept && in_data.req_type == REQ_DISCARD) begin
      pst_nxt = PST_EMPTY;
      cnt_nxt = '0;
    end

    if (step_fire) begin
      // Held sequence update.
      case (tr.act)
        ACT_HOLD: begin
          if (pst_r == PST_EMPTY) begin
            head_nxt = pos;
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          pst_nxt = tr.nst;
        end
        ACT_DONE, ACT_BAD: begin
          cnt_nxt = '0;
          pst_nxt = PST_EMPTY;
        end
        default: begin
        end
      endcase

      if (fsm_r == S_IDLE) begin
        end_nxt = wp;
      end
      cur_nxt = ram_raddr;

      // Result handling: one result is kept back so the last one is known.
      if (emit && !scan_end) begin
        pend_nxt   = emit_byte;
        pend_v_nxt = 1'b1;
        ld.load    = pend_v_r;
      end else if (emit && scan_end) begin
        if (pend_v_r) begin
          ld.load  = 1'b1;
          pend_nxt = emit_byte;
        end else begin
          ld.load = 1'b1;
          ld.beat = '{out_byte: emit_byte, last_byte: 1'b1};
        end
      end else if (scan_end && pend_v_r) begin
        ld.load    = 1'b1;
        ld.beat    = '{out_byte: pend_r, last_byte: 1'b1};
        pend_v_nxt = 1'b0;
      end

      if (scan_end) begin
        fsm_nxt = (emit && pend_v_r) ? S_FLUSH : S_IDLE;
      end else begin
        fsm_nxt = S_EXEC;
      end
    end

    // A read of the ring entry written in the same cycle takes the new byte.
    if (ram_re) begin
      fwd_nxt = ram_we && (wp == ram_raddr);
    end

    // Final result of the beat after a pending one went out.
    if (fsm_r == S_FLUSH && free) begin
      ld.load    = 1'b1;
      ld.beat    = '{out_byte: pend_r, last_byte: 1'b1};
      pend_v_nxt = 1'b0;
      fsm_nxt    = S_IDLE;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r    <= S_IDLE;
      pst_r    <= PST_EMPTY;
      cnt_r    <= '0;
      head_r   <= '0;
      pend_v_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      fsm_r    <= fsm_nxt;
      pst_r    <= pst_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      pend_v_r <= pend_v_nxt;
      fwd_r    <= fwd_nxt;
    end
  end

  // Pointers and data registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    end_r  <= end_nxt;
    pend_r <= pend_nxt;
    if (ram_re) begin
      fwd_byte_r <= in_data.in_byte;
    end
  end

endmodule

// ----- src/ansi_escape_stripper_top.sv -----
// ----------------------------------------------------------------------------
// ansi_escape_stripper_top: ANSI escape sequence filter
// Passes on terminal output bytes with CSI, OSC and two-byte escapes removed.
// ----------------------------------------------------------------------------
// Each in_ beat carries one terminal byte (or a discard request) and yields
// zero or more out_ beats; last_byte marks the final result of a beat. One
// byte per clock streams through while the consumer keeps out_ready high.
// When a held sequence turns out malformed or would exceed MAX_HELD bytes,
// its ESC goes out as a literal and the bytes after it are re-read from
// the ring memory one per cycle while out_ready stays high. Each byte after
// the ESC is read once, and the new byte once more when an ESC held at the
// end of an OSC turns out malformed as well, so a beat re-reads at most
// MAX_HELD + 1 bytes. When two results are still due at the end of a beat,
// the last one goes out from a flush state. The held store needs no
// clearing after reset.
module ansi_escape_stripper_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aes_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aes_pkg::out_beat_t  out_data
);
  import aes_pkg::*;

  out_load_t ld;
  logic      free;

  // Scanner with the held byte ring.
  aes_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .free     (free),
    .ld       (ld)
  );

  // Output register toward the consumer.
  aes_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/ansi_escape_stripper_top_test.sv -----
// ----------------------------------------------------------------------------
// ansi_escape_stripper_top_test: self-checking bench for the escape filter
// Feeds terminal bytes and discard requests, predicts the stripped byte
// stream with a scanner of its own and checks every out_ beat against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ansi_escape_stripper_top_test;
  import aes_pkg::*;

  // One stimulus row; a typed row carries its results written out by hand.
  typedef struct {
    in_beat_t   beat;
    bit         typed;
    int         n_exp;
    logic [7:0] exp0;
    logic [7:0] exp1;
  } stim_row_t;

  localparam int RAND_ITEMS = 134;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  stim_row_t row_q[$];
  stim_row_t offer_q[$];
  out_beat_t stripped_q[$];
  int        err_cnt = 0;
  int        idle_phase = 0;

  // Predictor state: the held partial sequence and the scan buffer.
  logic [7:0] partial_seq [MAX_HELD];
  int         partial_len = 0;
  logic [7:0] scan_buf [MAX_HELD + 1];
  int         scan_n;

  ansi_escape_stripper_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Length of a complete sequence starting with ESC at scan_buf[s], or 0.
  // On 0, more tells whether the sequence could still become valid.
  function automatic int esc_seq_len(input int s, output bit more);
    int j;
    more = 1'b0;
    if (scan_n - s < 2) begin
      more = 1'b1;
      return 0;
    end
    if (scan_buf[s+1] == CSI_CODE) begin
      j = s + 2;
      while (j < scan_n && scan_buf[j] >= PAR_LO && scan_buf[j] <= PAR_HI) j++;
      while (j < scan_n && scan_buf[j] >= INT_LO && scan_buf[j] <= INT_HI) j++;
      if (j >= scan_n) begin
        more = 1'b1;
        return 0;
      end
      if (scan_buf[j] >= FIN_LO && scan_buf[j] <= FIN_HI) return j + 1 - s;
      return 0;
    end
    if (scan_buf[s+1] == OSC_CODE) begin
      for (j = s + 2; j < scan_n; j++) begin
        if (scan_buf[j] == BEL_CODE) return j + 1 - s;
        if (scan_buf[j] == ESC_CODE) begin
          if (j + 1 >= scan_n) begin
            more = 1'b1;
            return 0;
          end
          if (scan_buf[j+1] == ST_CODE) return j + 2 - s;
          return 0;
        end
      end
      more = 1'b1;
      return 0;
    end
    if (scan_buf[s+1] >= FIN_LO && scan_buf[s+1] <= ESC2_HI) return 2;
    return 0;
  endfunction

  // Rescan the held bytes plus the new one and queue the bytes that survive.
  task automatic strip_step(input in_beat_t beat);
    int        i;
    int        k;
    int        m;
    int        n_out;
    bit        more;
    out_beat_t r;
    if (beat.req_type == REQ_DISCARD) begin
      partial_len = 0;
      return;
    end
    for (k = 0; k < partial_len; k++) scan_buf[k] = partial_seq[k];
    scan_buf[partial_len] = beat.in_byte;
    scan_n = partial_len + 1;
    partial_len = 0;
    n_out = 0;
    i = 0;
    while (i < scan_n) begin
      if (scan_buf[i] == ESC_CODE) begin
        m = esc_seq_len(i, more);
        if (m > 0) begin
          i += m;
          continue;
        end
        // Unfinished and still fits: hold it and stop.
        if (more && scan_n - i <= MAX_HELD) begin
          for (k = i; k < scan_n; k++) partial_seq[k-i] = scan_buf[k];
          partial_len = scan_n - i;
          break;
        end
      end
      r.out_byte = scan_buf[i];
      r.last_byte = 1'b0;
      stripped_q.push_back(r);
      n_out++;
      i++;
    end
    if (n_out > 0) begin
      r = stripped_q.pop_back();
      r.last_byte = 1'b1;
      stripped_q.push_back(r);
    end
  endtask

  // Stimulus builders.
  task automatic add_byte(input logic [7:0] b);
    stim_row_t row;
    row = '{beat: '{req_type: REQ_DATA, in_byte: b}, typed: 1'b0, n_exp: 0,
            exp0: 8'h00, exp1: 8'h00};
    row_q.push_back(row);
  endtask

  task automatic add_typed(input logic req, input logic [7:0] b, input int n,
                           input logic [7:0] e0, input logic [7:0] e1);
    stim_row_t row;
    row = '{beat: '{req_type: req, in_byte: b}, typed: 1'b1, n_exp: n,
            exp0: e0, exp1: e1};
    row_q.push_back(row);
  endtask

  task automatic add_discard();
    stim_row_t row;
    row = '{beat: '{req_type: REQ_DISCARD, in_byte: 8'($urandom_range(255))},
            typed: 1'b0, n_exp: 0, exp0: 8'h00, exp1: 8'h00};
    row_q.push_back(row);
  endtask

  // Random OSC body byte: anything but BEL and ESC.
  function automatic logic [7:0] osc_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == BEL_CODE || b == ESC_CODE);
    return b;
  endfunction

  task automatic add_random_seq();
    int         k;
    int         len;
    logic [7:0] b;
    case ($urandom_range(11))
      0, 1: begin
        len = $urandom_range(4, 1);
        for (k = 0; k < len; k++) add_byte(8'($urandom_range(255)));
      end
      2, 3: begin
        // Well-formed CSI.
        add_byte(ESC_CODE);
        add_byte(CSI_CODE);
        len = $urandom_range(4);
        for (k = 0; k < len; k++) add_byte(8'($urandom_range(PAR_HI, PAR_LO)));
        len = $urandom_range(2);
        for (k = 0; k < len; k++) add_byte(8'($urandom_range(INT_HI, INT_LO)));
        add_byte(8'($urandom_range(FIN_HI, FIN_LO)));
      end
      4: begin
        // CSI with a final byte outside every class.
        add_byte(ESC_CODE);
        add_byte(CSI_CODE);
        len = $urandom_range(2);
        for (k = 0; k < len; k++) add_byte(8'($urandom_range(PAR_HI, PAR_LO)));
        do b = 8'($urandom_range(255)); while (b >= INT_LO && b <= FIN_HI);
        add_byte(b);
      end
      5, 6: begin
        // OSC ended by BEL or by ESC backslash.
        add_byte(ESC_CODE);
        add_byte(OSC_CODE);
        len = $urandom_range(8);
        for (k = 0; k < len; k++) add_byte(osc_body_byte());
        if ($urandom_range(1)) begin
          add_byte(BEL_CODE);
        end else begin
          add_byte(ESC_CODE);
          add_byte(ST_CODE);
        end
      end
      7: begin
        // OSC broken by an ESC that is not followed by backslash.
        add_byte(ESC_CODE);
        add_byte(OSC_CODE);
        len = $urandom_range(4);
        for (k = 0; k < len; k++) add_byte(osc_body_byte());
        add_byte(ESC_CODE);
        do b = 8'($urandom_range(255)); while (b == ST_CODE);
        add_byte(b);
      end
      8: begin
        // Long OSC around the store capacity, often overflowing it.
        add_byte(ESC_CODE);
        add_byte(OSC_CODE);
        len = $urandom_range(MAX_HELD + 6, MAX_HELD - 4);
        for (k = 0; k < len; k++) add_byte(osc_body_byte());
        if ($urandom_range(1)) add_byte(BEL_CODE);
      end
      9: begin
        add_byte(ESC_CODE);
        add_byte(8'($urandom_range(ESC2_HI, FIN_LO)));
      end
      10: begin
        // ESC followed by a byte with no meaning.
        add_byte(ESC_CODE);
        do b = 8'($urandom_range(255)); while (b >= FIN_LO && b <= ESC2_HI);
        add_byte(b);
      end
      default: begin
        // Discard, in half the cases after a partial sequence that it drops.
        if ($urandom_range(1)) begin
          add_byte(ESC_CODE);
          add_byte($urandom_range(1) ? CSI_CODE : OSC_CODE);
          len = $urandom_range(3);
          for (k = 0; k < len; k++) add_byte(8'($urandom_range(PAR_HI, PAR_LO)));
        end
        add_discard();
      end
    endcase
  endtask

  // Result side: random stalls, plus one long hold-off once idling stops.
  initial begin
    int hold;
    bit held_off;
    hold = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_phase == 2 && !held_off) begin
        held_off = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= ($urandom_range(99) >= (idle_phase == 0 ? 45 :
                                             idle_phase == 1 ? 22 : 0));
      end
    end
  end

  // Predict on every accepted input beat, check every accepted output beat.
  always @(posedge clk) begin
    stim_row_t row;
    out_beat_t want;
    int        qlen;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        row = offer_q.pop_front();
        qlen = stripped_q.size();
        strip_step(in_data);
        if (row.typed) begin
          while (stripped_q.size() > qlen) void'(stripped_q.pop_back());
          if (row.n_exp == 1) begin
            stripped_q.push_back('{out_byte: row.exp0, last_byte: 1'b1});
          end else if (row.n_exp == 2) begin
            stripped_q.push_back('{out_byte: row.exp0, last_byte: 1'b0});
            stripped_q.push_back('{out_byte: row.exp1, last_byte: 1'b1});
          end
        end
      end
      if (out_valid && out_ready) begin
        if (stripped_q.size() == 0) begin
          $error("unexpected out beat: out_byte %h last_byte %b",
                 out_data.out_byte, out_data.last_byte);
          err_cnt++;
        end else begin
          want = stripped_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
            err_cnt++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            $error("last_byte: expected %b, got %b", want.last_byte, out_data.last_byte);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Main sequence: build the stimulus, drive it, drain, report.
  initial begin
    int total;
    int idx;
    int tx_idle;
    int n_directed;

    // Directed rows: extremes, each sequence kind and the special cases.
    add_typed(REQ_DATA, 8'h41, 1, 8'h41, 8'h00);
    add_typed(REQ_DATA, 8'h00, 1, 8'h00, 8'h00);
    add_typed(REQ_DATA, 8'hFF, 1, 8'hFF, 8'h00);
    add_typed(REQ_DATA, ESC_CODE, 0, 8'h00, 8'h00);
    add_byte(CSI_CODE);
    add_byte(PAR_HI);
    add_byte(INT_HI);
    add_byte(FIN_HI);
    // CSI with a bad final byte.
    add_byte(ESC_CODE);
    add_byte(CSI_CODE);
    add_byte(8'h1F);
    // OSC ended by BEL, then an empty OSC ended by ESC backslash.
    add_byte(ESC_CODE);
    add_byte(OSC_CODE);
    add_byte(PAR_LO);
    add_byte(BEL_CODE);
    add_byte(ESC_CODE);
    add_byte(OSC_CODE);
    add_byte(ESC_CODE);
    add_byte(ST_CODE);
    // Two-byte escape at the top of its range.
    add_byte(ESC_CODE);
    add_typed(REQ_DATA, ESC2_HI, 0, 8'h00, 8'h00);
    // ESC followed by a byte with no meaning goes out as literals.
    add_typed(REQ_DATA, ESC_CODE, 0, 8'h00, 8'h00);
    add_typed(REQ_DATA, 8'h01, 2, ESC_CODE, 8'h01);
    // Discard drops the held ESC.
    add_typed(REQ_DATA, ESC_CODE, 0, 8'h00, 8'h00);
    add_typed(REQ_DISCARD, 8'hFF, 0, 8'h00, 8'h00);
    add_typed(REQ_DATA, 8'h42, 1, 8'h42, 8'h00);
    n_directed = row_q.size();

    while (row_q.size() < n_directed + RAND_ITEMS) add_random_seq();
    total = row_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the rows; the idling pattern changes by thirds of the run.
    for (idx = 0; idx < total; idx++) begin
      idle_phase = (idx * 3) / total;
      tx_idle = (idle_phase == 0) ? 22 : (idle_phase == 1) ? 45 : 0;
      while ($urandom_range(99) < tx_idle) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= row_q[idx].beat;
      offer_q.push_back(row_q[idx]);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (offer_q.size() != 0 || stripped_q.size() != 0) @(posedge clk);
    repeat (2 * MAX_HELD + 8) @(posedge clk);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/aes_pkg.sv
src/aes_ram.sv
src/aes_outreg.sv
src/aes_scan.sv
src/ansi_escape_stripper_top.sv
tb/ansi_escape_stripper_top_test.sv
